// ===== design/bdel_pkg.sv =====
// Package for the bounded double-ended list unit.
// Holds the request and response word types, request and status codes,
// and default sizes. No dependencies.
`default_nettype none

package bdel_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 9;

  localparam int unsigned DEF_CAPACITY  = 256;
  localparam int unsigned DEF_ELEM_BITS = 32;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_REM_HEAD = 3'd2,
    REQ_REM_TAIL = 3'd3,
    REQ_RD_HEAD  = 3'd4,
    REQ_RD_TAIL  = 3'd5,
    REQ_RD_INDEX = 3'd6,
    REQ_SIZE     = 3'd7
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [DATA_W-1:0]  entry_data;
    logic [POS_W-1:0]   position;
  } req_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] count_now;
    status_e            status;
  } rsp_word_t;

endpackage

`default_nettype wire

// ===== design/bounded_double_ended_list_unit.sv =====
// Bounded double-ended list unit: circular element store with head pointer.
// Depends on bdel_pkg.
//
// One request word per cycle is taken while the response side keeps up; each
// request gives one response word in the cycle after acceptance, the element
// store being read synchronously (one port, one access per request). A stalled
// response holds off the next request. Inserts into a full list and removals
// from an empty list leave the list unchanged and are flagged; read data is
// zero unless a read succeeded. The store has no reset; only slots of live
// elements are ever read.
`default_nettype none

module bounded_double_ended_list_unit #(
  parameter int unsigned CAPACITY  = bdel_pkg::DEF_CAPACITY,
  parameter int unsigned ELEM_BITS = bdel_pkg::DEF_ELEM_BITS
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 req_valid_i,
  output logic                req_ready_o,
  input  bdel_pkg::req_word_t req_i,
  output logic                rsp_valid_o,
  input  wire                 rsp_ready_i,
  output bdel_pkg::rsp_word_t rsp_o
);
  import bdel_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  logic [ELEM_BITS-1:0] mem_q [CAPACITY];
  logic [ELEM_BITS-1:0] rdata_q;

  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rsp_valid_q;
  status_e       st_q, st_d;
  logic          rd_ok_q, rd_ok_d;

  logic          accept;
  logic          full, empty;
  logic [XW-1:0] cnt_x, off_x;
  logic [XW:0]   sum, slot_x;
  logic [PW-1:0] slot, head_dec, head_inc, addr;
  logic          mem_we, mem_re;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);
  assign cnt_x = XW'(count_q);

  assign head_dec = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    unique case (req_i.req_type)
      REQ_INS_TAIL: off_x = cnt_x;
      REQ_RD_TAIL:  off_x = cnt_x - 1'b1;
      REQ_RD_INDEX: off_x = XW'(req_i.position);
      default:      off_x = '0;
    endcase
  end

  assign sum    = (XW + 1)'(head_q) + (XW + 1)'(off_x);
  assign slot_x = (sum >= (XW + 1)'(CAPACITY)) ? sum - (XW + 1)'(CAPACITY) : sum;
  assign slot   = slot_x[PW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    st_d    = ST_OK;
    rd_ok_d = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    addr    = slot;
    unique case (req_i.req_type)
      REQ_INS_HEAD: begin
        addr = head_dec;
        if (full) begin
          st_d = ST_FULL;
        end else begin
          head_d  = head_dec;
          count_d = count_q + 1'b1;
          mem_we  = 1'b1;
        end
      end
      REQ_INS_TAIL: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          mem_we  = 1'b1;
        end
      end
      REQ_REM_HEAD: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      REQ_REM_TAIL: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      REQ_RD_HEAD, REQ_RD_TAIL: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          rd_ok_d = 1'b1;
          mem_re  = 1'b1;
        end
      end
      REQ_RD_INDEX: begin
        if (XW'(req_i.position) >= cnt_x) begin
          st_d = ST_RANGE;
        end else begin
          rd_ok_d = 1'b1;
          mem_re  = 1'b1;
        end
      end
      REQ_SIZE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem_q[addr] <= ELEM_BITS'(req_i.entry_data);
    end
    if (accept && mem_re) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q    <= st_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  assign rsp_valid_o         = rsp_valid_q;
  assign rsp_o.read_data     = rd_ok_q ? DATA_W'(rdata_q) : '0;
  assign rsp_o.count_now     = COUNT_W'(count_q);
  assign rsp_o.status        = st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= PW'(CAPACITY - 1))
    else $error("head pointer out of range");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != ST_OK) |-> rsp_o.read_data == '0)
    else $error("flagged response carries data");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && ((req_i.req_type == REQ_INS_HEAD) || (req_i.req_type == REQ_INS_TAIL))
    |=> $stable(count_q) && $stable(head_q))
    else $error("insert into full list changed state");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_o)
    else $error("accepted request gave no response");

endmodule

`default_nettype wire
